>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the unicode escape decoder.
// Users must have clk_i and rst_ni in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define UED_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Checks that a condition is never true outside of reset.
`define UED_ASSERT_NEVER(lbl, cond) \
  `UED_ASSERT(lbl, !(cond))

`endif

>>> hw/rtl/ued_pkg.sv
// Package for the unicode escape decoder: word and job types, code unit constants
// and hex digit helpers. Has no dependencies.
`default_nettype none

package ued_pkg;

  localparam logic [15:0] BackslashUnit = 16'h005C;
  localparam logic [15:0] LetterUUnit   = 16'h0075;
  localparam int          HeldMax       = 5;
  localparam int          DigitSlots    = 3;
  localparam int          QueueDepth    = 2;  // power of two
  localparam int          QPtrW         = $clog2(QueueDepth);

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_unit;
    logic        last_of_run;
    logic        stream_done;
  } out_word_t;

  // One input's worth of output: a flush of held units (backslash, 'u',
  // then digits), an optional tail unit, and the end of stream marker.
  typedef struct packed {
    logic [2:0]                 flush_cnt;
    logic [DigitSlots-1:0][6:0] digits;
    logic                       has_tail;
    logic [15:0]                tail_unit;
    logic                       eos;
  } job_t;

  function automatic logic is_hex_unit(input logic [15:0] u);
    logic [6:0] c;
    c = u[6:0];
    return (u[15:7] == 9'd0) &&
           (((c >= 7'h30) && (c <= 7'h39)) ||
            ((c >= 7'h41) && (c <= 7'h46)) ||
            ((c >= 7'h61) && (c <= 7'h66)));
  endfunction

  // Only valid for a code that is a hex digit.
  function automatic logic [3:0] hex_nibble(input logic [6:0] c);
    return (c[6:4] == 3'h3) ? c[3:0] : 4'(c[3:0] + 4'd9);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ued_front.sv
// Front end of the unicode escape decoder: tracks the partial escape match
// and turns each input word into at most one output job. Depends on ued_pkg.
`default_nettype none

module ued_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ued_pkg::in_word_t in_word_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output ued_pkg::job_t     push_job_o
);
  import ued_pkg::*;

  logic [2:0]                 held_q, held_d;
  logic [DigitSlots-1:0][6:0] digits_q, digits_d;
  logic                       accept;
  logic [15:0]                u;
  logic                       is_bs, is_letter_u, is_hex;
  logic                       brk;
  logic [1:0]                 slot;
  job_t                       job;

  assign u           = in_word_i.code_unit;
  assign is_bs       = (u == BackslashUnit);
  assign is_letter_u = (u == LetterUUnit);
  assign is_hex      = is_hex_unit(u);
  assign slot        = 2'(held_q - 3'd2);

  always_comb begin
    held_d        = held_q;
    digits_d      = digits_q;
    brk           = 1'b0;
    job.flush_cnt = 3'd0;
    job.digits    = digits_q;
    job.has_tail  = 1'b0;
    job.tail_unit = u;
    job.eos       = in_word_i.end_of_stream;

    if (held_q == 3'd0) begin
      brk = 1'b1;  // judged as if after a break with nothing held
    end else if (held_q == 3'd1) begin
      if (is_bs) begin
        job.flush_cnt = 3'd1;
        job.has_tail  = 1'b1;
        job.tail_unit = BackslashUnit;
        held_d        = 3'd0;
      end else if (is_letter_u) begin
        held_d = 3'd2;
      end else begin
        brk           = 1'b1;
        job.flush_cnt = 3'd1;
      end
    end else begin
      if (!is_hex) begin
        brk           = 1'b1;
        job.flush_cnt = held_q;
      end else if (held_q == 3'(HeldMax)) begin
        job.has_tail  = 1'b1;
        job.tail_unit = {hex_nibble(digits_q[0]), hex_nibble(digits_q[1]),
                         hex_nibble(digits_q[2]), hex_nibble(u[6:0])};
        held_d        = 3'd0;
      end else begin
        digits_d[slot] = u[6:0];
        held_d         = 3'(held_q + 3'd1);
      end
    end

    // A unit judged afresh either starts a new hold or passes through.
    if (brk) begin
      if (is_bs) begin
        held_d = 3'd1;
      end else begin
        held_d       = 3'd0;
        job.has_tail = 1'b1;
      end
    end

    // End of stream flushes whatever is still held.
    if (in_word_i.end_of_stream && (held_d != 3'd0)) begin
      if (brk) begin
        job.has_tail  = 1'b1;
        job.tail_unit = BackslashUnit;
      end else begin
        job.flush_cnt = held_d;
        job.digits    = digits_d;
      end
      held_d = 3'd0;
    end
  end

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && push_ready_i;
  assign push_valid_o = in_valid_i && ((job.flush_cnt != 3'd0) || job.has_tail);
  assign push_job_o   = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 3'd0;
    end else if (accept) begin
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      digits_q <= digits_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ued_queue.sv
// Short job queue between the front and back ends of the unicode escape decoder.
// Depends on ued_pkg.
`default_nettype none

module ued_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ued_pkg::job_t push_job_i,
  output logic          head_valid_o,
  output ued_pkg::job_t head_job_o,
  input  logic          pop_i
);
  import ued_pkg::*;

  job_t             entries_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != (QPtrW+1)'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ued_back.sv
// Back end of the unicode escape decoder: walks each job, one word per cycle
// if the output is free, into a registered output stage. Depends on ued_pkg.
`default_nettype none

module ued_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  ued_pkg::job_t      head_job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ued_pkg::out_word_t out_word_o
);
  import ued_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic [2:0] total;
  logic       last;
  logic       advance;
  logic       out_valid_q, out_valid_d;
  out_word_t  out_word_q, out_word_d;
  logic [15:0] unit;

  assign total   = 3'(head_job_i.flush_cnt + {2'b00, head_job_i.has_tail});
  assign last    = (idx_q == 3'(total - 3'd1));
  assign advance = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && last;

  always_comb begin
    unit = head_job_i.tail_unit;
    if (idx_q < head_job_i.flush_cnt) begin
      unique case (idx_q)
        3'd0:    unit = BackslashUnit;
        3'd1:    unit = LetterUUnit;
        3'd2:    unit = {9'd0, head_job_i.digits[0]};
        3'd3:    unit = {9'd0, head_job_i.digits[1]};
        3'd4:    unit = {9'd0, head_job_i.digits[2]};
        default: unit = head_job_i.tail_unit;
      endcase
    end
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (advance) begin
      out_valid_d            = 1'b1;
      out_word_d.out_unit    = unit;
      out_word_d.last_of_run = last;
      out_word_d.stream_done = last && head_job_i.eos;
      idx_d                  = last ? 3'd0 : 3'(idx_q + 3'd1);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

>>> hw/rtl/unicode_escape_decoder_unit.sv
// Top level of the unicode escape decoder: front end, job queue and back end.
// Depends on ued_pkg, ued_front, ued_queue, ued_back and assert_macros.svh.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o / in_word_i) takes one 16-bit
//   code unit per word, with end_of_stream marking the final unit of a text.
//   The output channel (out_valid_o / out_ready_i / out_word_o) returns the
//   decoded text one code unit per word; last_of_run flags the final word
//   caused by an input word and stream_done the final word of the text.
//   An input word that only extends a partial escape produces no output word.
//   An accepted word's job is registered in the queue, and its first output
//   word then in the output register. The front end takes one word per cycle
//   while the queue has room; the back end sends one output word per cycle
//   while the receiver is ready, and one input word causes at most six.
//   A two-entry job queue absorbs that; in_ready_o drops only while it is full.
//   When the receiver stalls, the output register holds its word, the back
//   end pauses, and the queue then fills before the input side stalls.
//   Reset clears the partial match, the queue and the output register; the
//   next word after reset or after an end of stream starts a fresh text.
`default_nettype none

module unicode_escape_decoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ued_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ued_pkg::out_word_t out_word_o
);
  import ued_pkg::*;

  `include "assert_macros.svh"

  logic push_valid, push_ready;
  job_t push_job;
  logic head_valid;
  job_t head_job;
  logic pop;

  // The front end classifies each code unit against the held escape prefix.
  ued_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // Jobs wait here so that a long flush does not stall the input at once.
  ued_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .head_valid_o (head_valid),
    .head_job_o   (head_job),
    .pop_i        (pop)
  );

  // The back end expands each job into output words.
  ued_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

  // The end of a text always closes the run of its input word.
  `UED_ASSERT(a_done_is_last, out_valid_o && out_word_o.stream_done |-> out_word_o.last_of_run)
  // A waiting job reaches an empty output register in the next cycle.
  `UED_ASSERT(a_back_moves, head_valid && !out_valid_o |=> out_valid_o)
  // The queue only fills up through an accepted input word.
  `UED_ASSERT(a_full_needs_push, $fell(in_ready_o) |-> $past(in_valid_i))

endmodule

`default_nettype wire

>>> sim/unicode_escape_decoder_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for unicode_escape_decoder_unit: directed and random text streams.
// Depends on ued_pkg and the unicode_escape_decoder_unit RTL only.

module unicode_escape_decoder_unit_test;
  import ued_pkg::*;

  localparam logic [15:0] SlashUnit  = ued_pkg::BackslashUnit;
  localparam logic [15:0] UUnit      = ued_pkg::LetterUUnit;
  localparam int          PhaseWords = 135;   // minimum random words per random phase
  localparam int          SqueezeLen = 300;   // receiver hold-off, in cycles
  localparam int          TailCycles = 20;    // settle time after the last word

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word     = '0;
  logic      out_valid_o;
  logic      out_ready   = 1'b0;
  out_word_t out_word_o;

  // Stimulus side: words waiting for the driver and the current idle rates.
  in_word_t  pending_words[$];
  int        queued_total  = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  // Receiver hold-off requests; the receiver counts the stretch itself.
  int        squeeze_req   = 0;
  int        squeeze_ack   = 0;
  int        hold_left     = 0;

  // Decoder state as the checker sees it, and the words it still waits for.
  logic [2:0] esc_depth = '0;
  logic [6:0] esc_digits [3];
  out_word_t  run_words[$];
  out_word_t  want_words[$];
  int         err_cnt = 0;

  unicode_escape_decoder_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_word_o  (out_word_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction.
  // ---------------------------------------------------------------------------

  // Value of a hex digit unit, or -1 when the unit is not a digit. Units with
  // a nonzero upper byte never count as digits.
  function automatic int digit_val(input logic [15:0] u);
    if (u >= 16'h0030 && u <= 16'h0039) return int'(u - 16'h0030);
    if (u >= 16'h0041 && u <= 16'h0046) return int'(u - 16'h0041) + 10;
    if (u >= 16'h0061 && u <= 16'h0066) return int'(u - 16'h0061) + 10;
    return -1;
  endfunction

  task automatic add_unit(input logic [15:0] v);
    out_word_t o;
    o.out_unit    = v;
    o.last_of_run = 1'b0;
    o.stream_done = 1'b0;
    run_words.push_back(o);
  endtask

  // Releases whatever part of an escape is held, unchanged and in order.
  task automatic release_hold();
    if (esc_depth >= 3'd1) add_unit(SlashUnit);
    if (esc_depth >= 3'd2) add_unit(UUnit);
    for (int i = 0; i + 2 < int'(esc_depth) && i < 3; i++) begin
      add_unit({9'd0, esc_digits[i]});
    end
    esc_depth = 3'd0;
  endtask

  // A unit seen with nothing held: a backslash opens a hold, all else passes.
  task automatic start_fresh(input logic [15:0] u);
    if (u == SlashUnit) begin
      esc_depth = 3'd1;
    end else begin
      add_unit(u);
    end
  endtask

  // Works out the output words that one accepted input word causes and
  // appends them to the expected words.
  task automatic predict_decode(input in_word_t w);
    logic [15:0] u;
    logic [15:0] val;
    int          hv;
    u = w.code_unit;
    run_words.delete();
    if (esc_depth > 3'd5) esc_depth = 3'd0;
    if (esc_depth == 3'd0) begin
      start_fresh(u);
    end else if (esc_depth == 3'd1) begin
      if (u == SlashUnit) begin
        // A doubled backslash goes out as two units and ends the hold.
        add_unit(SlashUnit);
        add_unit(SlashUnit);
        esc_depth = 3'd0;
      end else if (u == UUnit) begin
        esc_depth = 3'd2;
      end else begin
        release_hold();
        start_fresh(u);
      end
    end else begin
      hv = digit_val(u);
      if (hv < 0) begin
        // Broken match: held units go out as they were, then the unit is
        // judged as if nothing had been held.
        release_hold();
        start_fresh(u);
      end else if (esc_depth == 3'd5) begin
        val = {4'(digit_val({9'd0, esc_digits[0]})),
               4'(digit_val({9'd0, esc_digits[1]})),
               4'(digit_val({9'd0, esc_digits[2]})),
               4'(hv)};
        add_unit(val);
        esc_depth = 3'd0;
      end else begin
        esc_digits[esc_depth - 3'd2] = u[6:0];
        esc_depth = esc_depth + 3'd1;
      end
    end
    if (w.end_of_stream) release_hold();
    if (run_words.size() > 0) begin
      run_words[run_words.size() - 1].last_of_run = 1'b1;
      run_words[run_words.size() - 1].stream_done = w.end_of_stream;
    end
    foreach (run_words[i]) want_words.push_back(run_words[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pending words and predicts each one as it is accepted.
  // The next valid and payload are settled first and assigned once per edge,
  // so a word that follows directly keeps valid high without a glitch.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : feed
    logic     nxt_valid;
    in_word_t nxt_word;
    nxt_valid = in_valid;
    nxt_word  = in_word;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        predict_decode(in_word);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_words.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_word  = pending_words.pop_front();
      end
    end
    in_valid <= nxt_valid;
    in_word  <= nxt_word;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus long hold-offs on request so that the job
  // queue fills and the input side has to stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : sink
    logic nxt_ready;
    if (squeeze_req != squeeze_ack) begin
      squeeze_ack = squeeze_req;
      hold_left   = SqueezeLen;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      nxt_ready = 1'b0;
    end else begin
      nxt_ready = rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
    end
    out_ready <= nxt_ready;
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted output word is checked against the oldest
  // expected word, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (want_words.size() == 0) begin
        err_cnt = err_cnt + 1;
        if (err_cnt <= 10) begin
          $display("[%0t] unexpected word: unit %h last %b done %b", $realtime,
                   out_word_o.out_unit, out_word_o.last_of_run, out_word_o.stream_done);
        end
      end else begin
        want = want_words.pop_front();
        if (out_word_o.out_unit !== want.out_unit ||
            out_word_o.last_of_run !== want.last_of_run ||
            out_word_o.stream_done !== want.stream_done) begin
          err_cnt = err_cnt + 1;
          if (err_cnt <= 10) begin
            $display("[%0t] mismatch: expected unit %h last %b done %b, got unit %h last %b done %b",
                     $realtime, want.out_unit, want.last_of_run, want.stream_done,
                     out_word_o.out_unit, out_word_o.last_of_run, out_word_o.stream_done);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_unit(input logic [15:0] u, input logic eos);
    in_word_t w;
    w.code_unit     = u;
    w.end_of_stream = eos;
    pending_words.push_back(w);
    queued_total = queued_total + 1;
  endtask

  // Queues the characters of a string as code units; the last one may end
  // the stream.
  task automatic push_text(input string s, input logic eos_last);
    for (int i = 0; i < s.len(); i++) begin
      push_unit({8'h00, s[i]}, eos_last && (i == s.len() - 1));
    end
  endtask

  // A random hex digit unit, letters in either case.
  function automatic logic [15:0] rand_digit();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 16'h0030 + 16'(v);
    if ($urandom_range(0, 1) == 1) return 16'h0041 + 16'(v - 10);
    return 16'h0061 + 16'(v - 10);
  endfunction

  // Random content units in the random part end the stream now and then.
  task automatic push_rand(input logic [15:0] u);
    push_unit(u, $urandom_range(0, 29) == 0);
  endtask

  // One random piece of text. Complete escapes are the largest group of
  // pieces; the rest are plain text, doubled backslashes, broken escapes,
  // look-alikes with a wide upper byte, and raw noise.
  task automatic push_random_piece();
    int          kind;
    int          ndig;
    logic [15:0] u;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      push_rand(SlashUnit);
      push_rand(UUnit);
      for (int i = 0; i < 4; i++) push_rand(rand_digit());
    end else if (kind < 50) begin
      push_rand(16'($urandom_range(0, 16'hFFFF)));
    end else if (kind < 60) begin
      push_rand(SlashUnit);
      push_rand(SlashUnit);
    end else if (kind < 78) begin
      push_rand(SlashUnit);
      ndig = $urandom_range(0, 4);
      if (ndig > 0) push_rand(UUnit);
      for (int i = 1; i < ndig; i++) push_rand(rand_digit());
      case ($urandom_range(0, 3))
        0:       u = SlashUnit;
        1:       u = UUnit;
        2:       u = 16'($urandom_range(0, 16'h007F));
        default: u = 16'($urandom_range(0, 16'hFFFF));
      endcase
      push_rand(u);
    end else if (kind < 90) begin
      push_rand(16'($urandom_range(0, 16'h007F)));
    end else begin
      case ($urandom_range(0, 2))
        0:       u = SlashUnit;
        1:       u = UUnit;
        default: u = rand_digit();
      endcase
      u[15:8] = 8'($urandom_range(1, 255));
      push_rand(u);
    end
  endtask

  task automatic wait_fed();
    while (pending_words.size() > 0 || in_valid) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    int phase_start;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed text: field extremes, a mixed-case escape, a doubled
    // backslash followed by 'u' (which must pass), a match broken right
    // after the backslash, a match broken by a backslash that opens a new
    // escape, a match broken with all three digits held, a wide unit that
    // looks like a backslash, and an end of stream that flushes a hold.
    push_unit(16'h0000, 1'b0);
    push_unit(16'hFFFF, 1'b0);
    push_text("\\u00aF", 1'b0);
    push_text("\\\\u", 1'b0);
    push_text("\\x", 1'b0);
    push_text("\\u1\\uB2cg", 1'b0);
    push_unit(16'h015C, 1'b0);
    push_text("\\u7", 1'b1);

    // First idling phase: sender quiet 23 percent, receiver 47 percent.
    send_idle_pct = 23;
    recv_idle_pct = 47;
    phase_start = queued_total;
    while (queued_total - phase_start < PhaseWords) push_random_piece();
    wait_fed();

    // Swapped idling.
    send_idle_pct = 47;
    recv_idle_pct = 23;
    phase_start = queued_total;
    while (queued_total - phase_start < PhaseWords) push_random_piece();
    wait_fed();

    // Back pressure: the receiver holds off for a long stretch while random
    // units, a backslash before every eighth, keep coming, so the queue fills up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 40; i++) begin
      if (i % 8 == 3) push_rand(SlashUnit);
      push_rand(16'($urandom_range(0, 16'hFFFF)));
    end
    squeeze_req = squeeze_req + 1;
    wait_fed();

    // No idling on either side.
    phase_start = queued_total;
    while (queued_total - phase_start < PhaseWords) push_random_piece();
    wait_fed();

    while (want_words.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (want_words.size() > 0) err_cnt = err_cnt + 1;

    if (err_cnt == 0) begin
      $display("unicode_escape_decoder_unit verification clean");
    end else begin
      $display("unicode_escape_decoder_unit verification failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #3_000_000;
    $display("unicode_escape_decoder_unit verification failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ued_pkg.sv
hw/rtl/ued_front.sv
hw/rtl/ued_queue.sv
hw/rtl/ued_back.sv
hw/rtl/unicode_escape_decoder_unit.sv
sim/unicode_escape_decoder_unit_test.sv
